### rtl/core/lant_pkg.sv
`default_nettype none

package lant_pkg;

  // Default edge length of the square grid.
  localparam int unsigned GridSizeDefault = 64;

  // Operation codes carried by an input transaction.
  typedef enum logic [1:0] {
    OpForward  = 2'd0,
    OpBackward = 2'd1,
    OpPlace    = 2'd2,
    OpNop      = 2'd3
  } op_e;

  // Ant headings. Up moves to the next row, right to the next column.
  typedef enum logic [1:0] {
    HeadUp    = 2'd0,
    HeadRight = 2'd1,
    HeadDown  = 2'd2,
    HeadLeft  = 2'd3
  } heading_e;

  // Control bundle from the step core to the grid memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_data;
  } mem_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/langton_ant_stepper_unit.sv
// Reversible Langton's ant on a GRID_SIZE x GRID_SIZE bit grid held in a synchronous
// memory with one read port and one write port. Each input transaction is a forward step,
// a backward step, a placement or a no-op, and yields exactly one result transaction with
// the new position, heading, the color of the flipped cell and an out-of-range flag.
// After reset the grid is cleared to white by a sweep over all 2**(2*clog2(GRID_SIZE))
// cells (4096 at the default size of 64), during which in_ready_o stays low. After that an
// item is accepted only while no earlier item waits in the second stage: the first stage
// reads the cell under the ant, the second writes it back and updates the position, since
// the following item's cell address depends on that update. The item's result is then
// registered, and one further item can be accepted while a result waits to be taken.
`default_nettype none

module langton_ant_stepper_unit #(
  parameter int unsigned GRID_SIZE = lant_pkg::GridSizeDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [1:0]   operation_i,
  input  wire logic [5:0]   place_x_i,
  input  wire logic [5:0]   place_y_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic signed [7:0] ant_x_o,
  output logic signed [7:0] ant_y_o,
  output logic [1:0]        heading_o,
  output logic              flipped_color_o,
  output logic              out_of_range_o
);

  localparam int unsigned AddrWidth = 2 * $clog2(GRID_SIZE);

  lant_pkg::mem_ctrl_t  mem_ctrl;
  logic [AddrWidth-1:0] rd_addr, wr_addr;
  logic                 rd_data;
  logic                 init_done;

  // Step sequencing, ant state and result register.
  lant_step_core #(
    .GRID_SIZE (GRID_SIZE),
    .AddrWidth (AddrWidth)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .place_x_i       (place_x_i),
    .place_y_i       (place_y_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ant_x_o         (ant_x_o),
    .ant_y_o         (ant_y_o),
    .heading_o       (heading_o),
    .flipped_color_o (flipped_color_o),
    .out_of_range_o  (out_of_range_o),
    .mem_ctrl_o      (mem_ctrl),
    .rd_addr_o       (rd_addr),
    .wr_addr_o       (wr_addr),
    .rd_data_i       (rd_data),
    .init_done_i     (init_done)
  );

  // Grid cell storage with its post-reset clear sweep.
  lant_grid_mem #(
    .AddrWidth (AddrWidth)
  ) u_grid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mem_ctrl),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .rd_data_o   (rd_data),
    .init_done_o (init_done)
  );

endmodule

`default_nettype wire

### rtl/core/lant_grid_mem.sv
`default_nettype none

module lant_grid_mem #(
  parameter int unsigned AddrWidth = 2 * $clog2(lant_pkg::GridSizeDefault)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  lant_pkg::mem_ctrl_t        ctrl_i,
  input  wire logic [AddrWidth-1:0]  rd_addr_i,
  input  wire logic [AddrWidth-1:0]  wr_addr_i,
  output logic                       rd_data_o,
  output logic                       init_done_o
);

  logic                 grid_mem_q [2**AddrWidth];
  logic                 rd_data_q;
  logic [AddrWidth:0]   clr_cnt_q, clr_cnt_d;
  logic                 clearing;
  logic                 wr_en;
  logic [AddrWidth-1:0] wr_addr;
  logic                 wr_data;

  // The clear sweep runs once after reset; the counter's top bit marks completion.
  assign clearing    = !clr_cnt_q[AddrWidth];
  assign init_done_o = clr_cnt_q[AddrWidth];
  assign clr_cnt_d   = clearing ? clr_cnt_q + (AddrWidth + 1)'(1) : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // The sweep owns the write port until every cell is white.
  always_comb begin
    wr_en   = clearing | ctrl_i.wr_en;
    wr_addr = clearing ? clr_cnt_q[AddrWidth-1:0] : wr_addr_i;
    wr_data = clearing ? 1'b0 : ctrl_i.wr_data;
  end

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      grid_mem_q[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_data_q <= grid_mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/core/lant_step_core.sv
`default_nettype none

module lant_step_core #(
  parameter int unsigned GRID_SIZE = lant_pkg::GridSizeDefault,
  parameter int unsigned AddrWidth = 2 * $clog2(GRID_SIZE)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           operation_i,
  input  wire logic [5:0]           place_x_i,
  input  wire logic [5:0]           place_y_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [7:0]         ant_x_o,
  output logic signed [7:0]         ant_y_o,
  output logic [1:0]                heading_o,
  output logic                      flipped_color_o,
  output logic                      out_of_range_o,
  output lant_pkg::mem_ctrl_t       mem_ctrl_o,
  output logic [AddrWidth-1:0]      rd_addr_o,
  output logic [AddrWidth-1:0]      wr_addr_o,
  input  wire logic                 rd_data_i,
  input  wire logic                 init_done_i
);

  // Coordinates range over -1 .. GRID_SIZE, plus one more on a backward probe.
  localparam int unsigned CoordWidth = $clog2(GRID_SIZE + 1) + 1;
  localparam int unsigned LogWidth   = AddrWidth / 2;

  typedef logic signed [CoordWidth-1:0] coord_t;

  function automatic logic in_grid(coord_t c);
    return !c[CoordWidth-1] && (c < coord_t'(GRID_SIZE));
  endfunction

  function automatic coord_t step_dx(logic [1:0] h);
    coord_t d;
    case (h)
      lant_pkg::HeadRight: d = coord_t'(1);
      lant_pkg::HeadLeft:  d = coord_t'(-1);
      default:             d = '0;
    endcase
    return d;
  endfunction

  function automatic coord_t step_dy(logic [1:0] h);
    coord_t d;
    case (h)
      lant_pkg::HeadUp:   d = coord_t'(1);
      lant_pkg::HeadDown: d = coord_t'(-1);
      default:            d = '0;
    endcase
    return d;
  endfunction

  // Architectural ant state.
  coord_t     pos_x_q, pos_x_d;
  coord_t     pos_y_q, pos_y_d;
  logic [1:0] dir_q, dir_d;

  // Second stage: the accepted transaction waiting for its grid bit.
  logic              b_valid_q, b_valid_d;
  lant_pkg::op_e     b_op_q;
  coord_t            b_tx_q, b_ty_q;
  logic              b_tin_q;
  logic [5:0]        b_px_q, b_py_q;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic signed [7:0] ant_x_q, ant_y_q;
  logic [1:0]        heading_q;
  logic              flipped_q, flag_q;

  logic          in_fire, b_fire;
  lant_pkg::op_e op_in;
  coord_t        tx, ty;
  logic          t_in;
  logic [1:0]    turned;
  logic          flip, flag, wr, wr_bit;

  // First stage: pick the cell the operation touches and start its read.
  assign in_ready_o = init_done_i && !b_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign op_in      = lant_pkg::op_e'(operation_i);

  always_comb begin
    tx = pos_x_q;
    ty = pos_y_q;
    if (op_in == lant_pkg::OpBackward) begin
      tx = pos_x_q - step_dx(dir_q);
      ty = pos_y_q - step_dy(dir_q);
    end
    t_in = in_grid(tx) && in_grid(ty);
  end

  assign rd_addr_o = {ty[LogWidth-1:0], tx[LogWidth-1:0]};
  assign wr_addr_o = {b_ty_q[LogWidth-1:0], b_tx_q[LogWidth-1:0]};

  // Second stage retires when the result register is free or being drained.
  assign b_fire = b_valid_q && (!out_valid_q || out_ready_i);

  // Turn, flip and move using the cell color that the memory returned.
  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    dir_d   = dir_q;
    turned  = dir_q;
    flip    = 1'b0;
    flag    = 1'b0;
    wr      = 1'b0;
    wr_bit  = 1'b0;
    case (b_op_q)
      lant_pkg::OpForward: begin
        if (b_tin_q) begin
          turned  = rd_data_i ? dir_q + 2'd1 : dir_q - 2'd1;
          dir_d   = turned;
          wr      = 1'b1;
          wr_bit  = !rd_data_i;
          flip    = !rd_data_i;
          pos_x_d = b_tx_q + step_dx(turned);
          pos_y_d = b_ty_q + step_dy(turned);
          flag    = !(in_grid(pos_x_d) && in_grid(pos_y_d));
        end else begin
          flag = 1'b1;
        end
      end
      lant_pkg::OpBackward: begin
        if (b_tin_q) begin
          wr      = 1'b1;
          wr_bit  = !rd_data_i;
          flip    = !rd_data_i;
          dir_d   = !rd_data_i ? dir_q - 2'd1 : dir_q + 2'd1;
          pos_x_d = b_tx_q;
          pos_y_d = b_ty_q;
        end else begin
          flag = 1'b1;
        end
      end
      lant_pkg::OpPlace: begin
        if (32'(b_px_q) > GRID_SIZE - 1) begin
          pos_x_d = coord_t'(GRID_SIZE - 1);
          flag    = 1'b1;
        end else begin
          pos_x_d = coord_t'(b_px_q);
        end
        if (32'(b_py_q) > GRID_SIZE - 1) begin
          pos_y_d = coord_t'(GRID_SIZE - 1);
          flag    = 1'b1;
        end else begin
          pos_y_d = coord_t'(b_py_q);
        end
      end
      default: begin
        flag = 1'b1;
      end
    endcase
  end

  always_comb begin
    mem_ctrl_o.rd_en   = in_fire && t_in &&
                         (op_in == lant_pkg::OpForward || op_in == lant_pkg::OpBackward);
    mem_ctrl_o.wr_en   = b_fire && wr;
    mem_ctrl_o.wr_data = wr_bit;
  end

  // Handshake bookkeeping for the second stage and the result register.
  always_comb begin
    b_valid_d = b_valid_q;
    if (in_fire) begin
      b_valid_d = 1'b1;
    end else if (b_fire) begin
      b_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (b_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and ant state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      dir_q       <= lant_pkg::HeadUp;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
      if (b_fire) begin
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
        dir_q   <= dir_d;
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_op_q  <= op_in;
      b_tx_q  <= tx;
      b_ty_q  <= ty;
      b_tin_q <= t_in;
      b_px_q  <= place_x_i;
      b_py_q  <= place_y_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      ant_x_q   <= 8'(pos_x_d);
      ant_y_q   <= 8'(pos_y_d);
      heading_q <= dir_d;
      flipped_q <= flip;
      flag_q    <= flag;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ant_x_o         = ant_x_q;
  assign ant_y_o         = ant_y_q;
  assign heading_o       = heading_q;
  assign flipped_color_o = flipped_q;
  assign out_of_range_o  = flag_q;

endmodule

`default_nettype wire

### rtl/core/lant_checker.sv
`default_nettype none

module lant_checker #(
  parameter int unsigned GRID_SIZE = lant_pkg::GridSizeDefault
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic [1:0]        operation_i,
  input wire logic [5:0]        place_x_i,
  input wire logic [5:0]        place_y_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic signed [7:0] ant_x_o,
  input wire logic signed [7:0] ant_y_o,
  input wire logic [1:0]        heading_o,
  input wire logic              flipped_color_o,
  input wire logic              out_of_range_o
);

  // A stalled result keeps its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(ant_x_o) && $stable(ant_y_o) && $stable(heading_o) &&
      $stable(flipped_color_o) && $stable(out_of_range_o))
    else $error("stalled result changed");

  // An accepted transaction blocks the input while it waits in the second stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on consecutive cycles");

  // A result without the flag never has a negative coordinate (checked for GRID_SIZE up to 127).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_of_range_o |->
      (GRID_SIZE > 127) || (!ant_x_o[7] && !ant_y_o[7]))
    else $error("ant off the grid without out_of_range");

  // A waiting input transaction keeps its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(operation_i) && $stable(place_x_i) && $stable(place_y_i))
    else $error("stalled input changed");

endmodule

bind langton_ant_stepper_unit lant_checker #(.GRID_SIZE(GRID_SIZE)) u_checker (.*);

`default_nettype wire
